// ----- hdl/ilb_pkg.sv -----
// Shared types and constants of the indexed list buffer.
package ilb_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CMD_W      = 3;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 7;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_RESIZE = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [CNT_W-1:0]      lo;
    logic [CNT_W-1:0]      hi;
    logic [DATA_WIDTH-1:0] value;
    logic                  rd_en;
    logic [CNT_W-1:0]      rd_idx;
  } cell_ctrl_t;

endpackage

// ----- hdl/ilb_cell.sv -----
// One storage cell of the list: holds an entry, loads, or takes a neighbour's entry.
module ilb_cell (
  input  logic                          clk_i,
  input  ilb_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ilb_pkg::CNT_W-1:0]     cell_idx_i,
  input  logic [ilb_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [ilb_pkg::DATA_WIDTH-1:0] right_i,
  output logic [ilb_pkg::DATA_WIDTH-1:0] q_o,
  output logic [ilb_pkg::DATA_WIDTH-1:0] tap_o
);
  import ilb_pkg::*;

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        if (cell_idx_i >= ctrl_i.lo && cell_idx_i < ctrl_i.hi) data_d = ctrl_i.value;
      end
      CELL_INSERT: begin
        if (cell_idx_i == ctrl_i.lo) begin
          data_d = ctrl_i.value;
        end else if (cell_idx_i > ctrl_i.lo) begin
          data_d = left_i;
        end
      end
      CELL_ERASE: begin
        if (cell_idx_i >= ctrl_i.lo) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o   = data_q;
  assign tap_o = (ctrl_i.rd_en && cell_idx_i == ctrl_i.rd_idx) ? data_q : '0;

endmodule

// ----- hdl/ilb_ctrl.sv -----
// Command decode, position checks and element count of the list.
module ilb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  ilb_pkg::cmd_e                 cmd_i,
  input  logic [ilb_pkg::POS_W-1:0]     pos_i,
  input  logic [ilb_pkg::VAL_W-1:0]     value_i,
  input  logic [ilb_pkg::CNT_W-1:0]     new_len_i,
  output ilb_pkg::cell_ctrl_t           ctrl_o,
  output ilb_pkg::status_e              status_o,
  output logic [ilb_pkg::CNT_W-1:0]     count_o,
  output logic [ilb_pkg::CNT_W-1:0]     count_next_o
);
  import ilb_pkg::*;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   len_ext;
  logic [POS_W:0]   j_ext;
  logic [CNT_W-1:0] j_idx;
  logic             in_rd;
  logic             in_ins;
  logic             full;
  cell_ctrl_t       ctrl;
  status_e          status;

  always_comb begin
    pos_ext = {pos_i[POS_W-1], pos_i};
    len_ext = (POS_W+1)'(count_q);
    j_ext   = pos_i[POS_W-1] ? (len_ext + pos_ext) : pos_ext;
    j_idx   = j_ext[CNT_W-1:0];
    in_rd   = !j_ext[POS_W] && (j_ext < len_ext);
    in_ins  = !j_ext[POS_W] && (j_ext <= len_ext);
    full    = count_q >= CapCnt;

    ctrl.op     = CELL_HOLD;
    ctrl.lo     = '0;
    ctrl.hi     = '0;
    ctrl.value  = value_i[DATA_WIDTH-1:0];
    ctrl.rd_en  = 1'b0;
    ctrl.rd_idx = '0;
    status      = ST_OK;
    count_d     = count_q;

    case (cmd_i)
      CMD_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_LOAD;
          ctrl.lo = count_q;
          ctrl.hi = count_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_idx = count_q - 1'b1;
          count_d     = count_q - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!in_ins) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          ctrl.lo = j_idx;
          count_d = count_q + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (!in_rd) begin
          status = ST_RANGE;
        end else begin
          ctrl.op     = CELL_ERASE;
          ctrl.lo     = j_idx;
          ctrl.rd_en  = 1'b1;
          ctrl.rd_idx = j_idx;
          count_d     = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (!in_rd) begin
          status = ST_RANGE;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_idx = j_idx;
        end
      end
      CMD_WRITE: begin
        if (!in_rd) begin
          status = ST_RANGE;
        end else begin
          ctrl.op = CELL_LOAD;
          ctrl.lo = j_idx;
          ctrl.hi = j_idx + 1'b1;
        end
      end
      CMD_RESIZE: begin
        if (new_len_i > CapCnt) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_LOAD;
          ctrl.lo = count_q;
          ctrl.hi = new_len_i;
          count_d = new_len_i;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    if (!accept_i) ctrl.op = CELL_HOLD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign ctrl_o       = ctrl;
  assign status_o     = status;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

// ----- hdl/indexed_list_buffer_unit.sv -----
// Top level of the indexed list buffer: command decode, row of cells and result register.
// The list sits in a row of 64 cells, one entry each. On the beat that accepts a command,
// every cell loads, holds or takes its left or right neighbour's entry, so insert and erase
// move the whole tail on that beat whatever the position. A read,
// pop or erase picks its entry from the cells through an OR tree of per-cell taps. The result
// beat appears in the cycle after the command beat and sits in an output register; a new command
// is taken every cycle while that register is empty or being drained.
module indexed_list_buffer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] position, [39:8] item_value, [46:40] new_length, [47] zero
  input  logic [ilb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [2:0] command
  input  logic [ilb_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] result_value, [33:32] status, [40:34] length_after, [47:41] zero
  output logic [ilb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import ilb_pkg::*;

  logic                  s_beat;
  cell_ctrl_t            ctrl;
  status_e               status;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  out_valid_q;
  logic [VAL_W-1:0]      res_value_q;
  status_e               res_status_q;
  logic [CNT_W-1:0]      res_len_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  ilb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_beat),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .pos_i        (s_axis_tdata[7:0]),
    .value_i      (s_axis_tdata[39:8]),
    .new_len_i    (s_axis_tdata[46:40]),
    .ctrl_o       (ctrl),
    .status_o     (status),
    .count_o      (count),
    .count_next_o (count_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner_r
      assign right = cell_q[i+1];
    end
    ilb_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (CNT_W'(i)),
      .left_i     (left),
      .right_i    (right),
      .q_o        (cell_q[i]),
      .tap_o      (cell_tap[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_tap[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      res_value_q  <= VAL_W'(rd_data);
      res_status_q <= status;
      res_len_q    <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_len_q, res_status_q, res_value_q};

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_flag_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && status != ST_OK) |=> (count == $past(count)))
    else $error("flagged command changed the element count");

  a_flag_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status_q != ST_OK) |-> (res_value_q == '0))
    else $error("flagged command returned a non-zero value");

  a_len_tracks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> (res_len_q == count))
    else $error("reported length differs from element count");
`endif

endmodule

// ----- verif/testbench.sv -----
// Testbench of indexed_list_buffer_unit: shadow list predictor, stream drivers, result checks.
module testbench;
  import ilb_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] value;
    status_e          status;
    logic [CNT_W-1:0] length;
  } list_reply_t;

  class list_checker;
    logic [DATA_WIDTH-1:0] shadow_cells [CAPACITY];
    int                    shadow_len;
    list_reply_t           awaited_replies [$];
    int                    errors;

    function bit locate(int pos, int limit, output int idx);
      int j;
      j = (pos < 0) ? shadow_len + pos : pos;
      idx = j;
      return !(pos < -shadow_len || j < 0 || j >= limit);
    endfunction

    function void note_command(cmd_e cmd, logic signed [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val, logic [CNT_W-1:0] new_len);
      list_reply_t r;
      int          p;
      int          j;
      int          k;
      p        = pos;
      r.value  = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (shadow_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            shadow_cells[shadow_len] = val[DATA_WIDTH-1:0];
            shadow_len++;
          end
        end
        CMD_POP: begin
          if (shadow_len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            shadow_len--;
            r.value = shadow_cells[shadow_len];
          end
        end
        CMD_INSERT: begin
          if (!locate(p, shadow_len + 1, j)) begin
            r.status = ST_RANGE;
          end else if (shadow_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (k = shadow_len; k > j; k--) shadow_cells[k] = shadow_cells[k-1];
            shadow_cells[j] = val[DATA_WIDTH-1:0];
            shadow_len++;
          end
        end
        CMD_ERASE: begin
          if (!locate(p, shadow_len, j)) begin
            r.status = ST_RANGE;
          end else begin
            r.value = shadow_cells[j];
            for (k = j; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
            shadow_len--;
          end
        end
        CMD_READ: begin
          if (!locate(p, shadow_len, j)) r.status = ST_RANGE;
          else r.value = shadow_cells[j];
        end
        CMD_WRITE: begin
          if (!locate(p, shadow_len, j)) r.status = ST_RANGE;
          else shadow_cells[j] = val[DATA_WIDTH-1:0];
        end
        CMD_RESIZE: begin
          if (new_len > CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            while (shadow_len < new_len) begin
              shadow_cells[shadow_len] = val[DATA_WIDTH-1:0];
              shadow_len++;
            end
            shadow_len = new_len;
          end
        end
        default: begin
          shadow_len = 0;
        end
      endcase
      r.length = CNT_W'(shadow_len);
      awaited_replies.push_back(r);
    endfunction

    function void report(string field, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] beat);
      list_reply_t      want;
      logic [VAL_W-1:0] got_value;
      logic [ST_W-1:0]  got_status;
      logic [CNT_W-1:0] got_len;
      got_value  = beat[VAL_W-1:0];
      got_status = beat[VAL_W+ST_W-1:VAL_W];
      got_len    = beat[VAL_W+ST_W+CNT_W-1:VAL_W+ST_W];
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: expected none, got %h", $time, beat);
        return;
      end
      want = awaited_replies.pop_front();
      if (got_value !== want.value) report("result_value", want.value, got_value);
      if (got_status !== want.status) report("status", want.status, got_status);
      if (got_len !== want.length) report("length_after", want.length, got_len);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  list_checker sb;
  int          src_idle_pct  = 0;
  int          sink_stall_pct = 0;
  int          hold_left     = 0;
  bit          growing       = 1'b1;

  indexed_list_buffer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
  end

  task automatic send_beat(cmd_e cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic [CNT_W-1:0] new_len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, new_len, val, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(cmd, pos, val, new_len);
    @(negedge clk_i);
  endtask

  task automatic apply(cmd_e cmd, int pos, logic [VAL_W-1:0] val, int new_len);
    send_beat(cmd, POS_W'(pos), val, CNT_W'(new_len));
  endtask

  task automatic drive_random(int count);
    cmd_e cmd;
    int   len;
    int   w;
    int   r;
    int   hi;
    int   pos;
    int   new_len;
    repeat (count) begin
      len = sb.shadow_len;
      if (len == 0) growing = 1'b1;
      else if (len == CAPACITY && $urandom_range(5) == 0) growing = 1'b0;
      else if ($urandom_range(59) == 0) growing = !growing;
      w = $urandom_range(99);
      if (growing) begin
        if (w < 35) cmd = CMD_PUSH;
        else if (w < 55) cmd = CMD_INSERT;
        else if (w < 61) cmd = CMD_POP;
        else if (w < 68) cmd = CMD_ERASE;
        else if (w < 81) cmd = CMD_READ;
        else if (w < 92) cmd = CMD_WRITE;
        else if (w < 98) cmd = CMD_RESIZE;
        else cmd = CMD_CLEAR;
      end else begin
        if (w < 30) cmd = CMD_POP;
        else if (w < 50) cmd = CMD_ERASE;
        else if (w < 55) cmd = CMD_PUSH;
        else if (w < 60) cmd = CMD_INSERT;
        else if (w < 75) cmd = CMD_READ;
        else if (w < 87) cmd = CMD_WRITE;
        else if (w < 97) cmd = CMD_RESIZE;
        else cmd = CMD_CLEAR;
      end
      r  = $urandom_range(9);
      hi = (cmd == CMD_INSERT) ? len : len - 1;
      if (r < 8) begin
        if (hi < -len) pos = 0;
        else pos = int'($urandom_range(hi + len)) - len;
      end else if (r == 8) begin
        pos = $urandom_range(1) ? hi + 1 : -len - 1;
      end else begin
        pos = $urandom_range(255);
      end
      r = $urandom_range(9);
      if (r == 0) new_len = $urandom_range(127);
      else if (growing) new_len = $urandom_range(CAPACITY);
      else new_len = $urandom_range(len);
      apply(cmd, pos, $urandom(), new_len);
    end
  endtask

  initial begin
    sb = new;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apply(CMD_POP, 0, 32'h1234_5678, 0);
    apply(CMD_READ, 0, 32'h0, 0);
    apply(CMD_ERASE, 0, 32'h0, 0);
    apply(CMD_WRITE, 0, 32'hDEAD_BEEF, 0);
    apply(CMD_INSERT, 0, 32'hFFFF_FFFF, 0);
    apply(CMD_PUSH, 0, 32'h0000_0000, 0);
    apply(CMD_INSERT, -2, 32'hA5A5_A5A5, 0);
    apply(CMD_READ, -1, 32'h0, 0);
    apply(CMD_WRITE, 1, 32'h0000_0001, 0);
    apply(CMD_READ, 127, 32'h0, 0);
    apply(CMD_READ, -128, 32'h0, 0);
    apply(CMD_ERASE, -3, 32'h0, 0);
    apply(CMD_RESIZE, 0, 32'h8000_0000, CAPACITY);
    apply(CMD_PUSH, 0, 32'h5555_5555, 0);
    apply(CMD_INSERT, 0, 32'hAAAA_AAAA, 0);
    apply(CMD_INSERT, CAPACITY + 1, 32'hAAAA_AAAA, 0);
    apply(CMD_READ, CAPACITY - 1, 32'h0, 0);
    apply(CMD_READ, -CAPACITY, 32'h0, 0);
    apply(CMD_ERASE, CAPACITY - 1, 32'h0, 0);
    apply(CMD_INSERT, CAPACITY - 1, 32'h7FFF_FFFF, 0);
    apply(CMD_RESIZE, 0, 32'h0, 127);
    apply(CMD_RESIZE, 0, 32'h0, CAPACITY + 1);
    apply(CMD_RESIZE, 0, 32'h0, CAPACITY);
    apply(CMD_RESIZE, 0, 32'h0, 2);
    apply(CMD_CLEAR, 0, 32'h0, 0);
    apply(CMD_POP, 0, 32'h0, 0);

    drive_random(400);
    src_idle_pct = 71;
    drive_random(400);
    src_idle_pct   = 0;
    sink_stall_pct = 71;
    drive_random(400);
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    drive_random(400);
    // hold the output off long enough to back up the input
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 300;
    drive_random(50);

    s_axis_tvalid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** indexed_list_buffer_unit: PASSED **");
    end else begin
      $display("** indexed_list_buffer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** indexed_list_buffer_unit: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ilb_pkg.sv
hdl/ilb_cell.sv
hdl/ilb_ctrl.sv
hdl/indexed_list_buffer_unit.sv
verif/testbench.sv
